@@ sv/ahe_pkg.sv @@
// Shared types and constants for the adaptive Huffman encoder.
package ahe_pkg;

  localparam int NODE_W     = 10;    // node index and child field width
  localparam int WEIGHT_W   = 16;
  localparam int SYM_W      = 8;
  localparam int CODE_W     = 32;
  localparam int LEN_W      = 6;
  localparam int LIMIT_W    = 16;
  localparam int LEAF_SLOTS = 258;   // 256 bytes plus end and escape
  localparam int LOF_AW     = 9;     // address bits of the symbol-to-leaf store

  localparam logic [NODE_W-1:0]   SYM_END   = 10'd256;
  localparam logic [NODE_W-1:0]   SYM_ESC   = 10'd257;
  localparam logic [LIMIT_W-1:0]  LIMIT_MAX = 16'h8000;
  localparam logic [LIMIT_W-1:0]  LIMIT_MIN = 16'd4;

  typedef struct packed {
    logic [NODE_W-1:0]   child;
    logic                leaf;
    logic [WEIGHT_W-1:0] weight;
  } node_rec_t;

  localparam int NODE_REC_W = $bits(node_rec_t);

endpackage

@@ sv/ahe_in_if.sv @@
// Input channel: one byte or an end-of-stream marker per item.
interface ahe_in_if import ahe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             end_of_stream;

  modport source (output valid, symbol, end_of_stream, input ready);
  modport sink   (input valid, symbol, end_of_stream, output ready);
endinterface

@@ sv/ahe_out_if.sv @@
// Output channel: one path code, with optional literal, per item.
interface ahe_out_if import ahe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_len;
  logic [SYM_W-1:0]  literal;
  logic              literal_valid;

  modport source (output valid, code_bits, code_len, literal, literal_valid, input ready);
  modport sink   (input valid, code_bits, code_len, literal, literal_valid, output ready);
endinterface

@@ sv/ahe_ram.sv @@
// Generic one-write, one-read RAM with registered read data.
module ahe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/adaptive_huffman_encoder.sv @@
// Adaptive Huffman (FGK) encoder with escape symbol, memory based sequencer.
//
//  channel    dir  handshake            payload
//  sym_in     in   valid/ready          symbol[7:0], end_of_stream
//  code_out   out  valid/ready          code_bits[31:0], code_len[5:0], literal[7:0],
//                                       literal_valid
//  cfg        in   cfg_wr_en (no wait)  cfg_wr_data[15:0] = rescale_limit
//
// One item at a time. Encoding reads the parent store once per tree level; the weight
// update reads the node store per level, per node passed in the leader scan and per
// swap, bound by the single read port of the node store. A rebuild sweeps the node
// store three times, with insertion shifts. Reset and end_of_stream run a clearing
// pass over max(NODE_COUNT, 258) entries with sym_in.ready low. A result waits in the
// output register; the update of the tree proceeds behind it.
module adaptive_huffman_encoder import ahe_pkg::*; #(
  parameter int NODE_COUNT    = 515,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  ahe_in_if.sink              sym_in,
  ahe_out_if.source           code_out,
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data
);

  localparam int ADDR_W    = $clog2(NODE_COUNT);
  localparam int CLR_DEPTH = (NODE_COUNT > LEAF_SLOTS) ? NODE_COUNT : LEAF_SLOTS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int SW        = NODE_W + 1;   // signed loop index width

  localparam logic [5:0] S_CLR   = 6'd0;
  localparam logic [5:0] S_IDLE  = 6'd1;
  localparam logic [5:0] S_LOF   = 6'd2;
  localparam logic [5:0] S_ESC   = 6'd3;
  localparam logic [5:0] S_ENC   = 6'd4;
  localparam logic [5:0] S_ENC_W = 6'd5;
  localparam logic [5:0] S_OUT   = 6'd6;
  localparam logic [5:0] S_ADD0  = 6'd7;
  localparam logic [5:0] S_ADD1  = 6'd8;
  localparam logic [5:0] S_ADD2  = 6'd9;
  localparam logic [5:0] S_ADD3  = 6'd10;
  localparam logic [5:0] S_ADD4  = 6'd11;
  localparam logic [5:0] S_UPD0  = 6'd12;
  localparam logic [5:0] S_UPD1  = 6'd13;
  localparam logic [5:0] S_UPD2  = 6'd14;
  localparam logic [5:0] S_UPD3  = 6'd15;
  localparam logic [5:0] S_WALK  = 6'd16;
  localparam logic [5:0] S_WALK1 = 6'd17;
  localparam logic [5:0] S_SCAN  = 6'd18;
  localparam logic [5:0] S_SCAN1 = 6'd19;
  localparam logic [5:0] S_SWP   = 6'd20;
  localparam logic [5:0] S_SWP1  = 6'd21;
  localparam logic [5:0] S_SWP2  = 6'd22;
  localparam logic [5:0] S_SWP3  = 6'd23;
  localparam logic [5:0] S_SWP4  = 6'd24;
  localparam logic [5:0] S_NEXT  = 6'd25;
  localparam logic [5:0] S_NEXT1 = 6'd26;
  localparam logic [5:0] S_P1    = 6'd27;
  localparam logic [5:0] S_P1W   = 6'd28;
  localparam logic [5:0] S_P2    = 6'd29;
  localparam logic [5:0] S_P2A   = 6'd30;
  localparam logic [5:0] S_P2B   = 6'd31;
  localparam logic [5:0] S_P2K   = 6'd32;
  localparam logic [5:0] S_P2KW  = 6'd33;
  localparam logic [5:0] S_P2M   = 6'd34;
  localparam logic [5:0] S_P2MW  = 6'd35;
  localparam logic [5:0] S_P2F   = 6'd36;
  localparam logic [5:0] S_P3    = 6'd37;
  localparam logic [5:0] S_P3W   = 6'd38;
  localparam logic [5:0] S_RL0   = 6'd39;
  localparam logic [5:0] S_RL1   = 6'd40;

  // index clip: anything past the node store maps to the root
  function automatic logic [NODE_W-1:0] clip(input logic [NODE_W-1:0] v);
    return (v < NODE_COUNT) ? v : '0;
  endfunction

  // control
  logic [5:0]           state;
  logic [5:0]           rl_ret;
  logic [CLR_W-1:0]     clr_cnt;
  logic [NODE_W-1:0]    nf;              // first free node
  logic [LIMIT_W-1:0]   rescale_limit;
  logic                 out_valid;

  // working registers
  logic [SYM_W-1:0]     sym_q;
  logic                 eos_q;
  logic                 lit_q;
  logic [NODE_W-1:0]    enc_node;
  logic [NODE_W-1:0]    steps;
  logic [CODE_W-1:0]    code;
  logic [LEN_W-1:0]     len;
  logic [NODE_W-1:0]    cur;
  logic [NODE_W-1:0]    lead;
  node_rec_t            rec_a;
  node_rec_t            rec_b;
  logic signed [SW-1:0] ri, rj, rk, rm;
  logic [WEIGHT_W-1:0]  wsum;
  logic [NODE_W-1:0]    rl_child;
  logic                 rl_leaf;
  logic [NODE_W-1:0]    rl_pos;

  // output register
  logic [CODE_W-1:0]    out_code;
  logic [LEN_W-1:0]     out_len;
  logic [SYM_W-1:0]     out_lit;
  logic                 out_lit_valid;

  // memories
  logic                 node_we;
  logic [ADDR_W-1:0]    node_waddr, node_raddr;
  node_rec_t            node_wdata, node_rdata;
  logic                 par_we;
  logic [ADDR_W-1:0]    par_waddr, par_raddr;
  logic [NODE_W-1:0]    par_wdata, par_rdata;
  logic                 lof_we;
  logic [LOF_AW-1:0]    lof_waddr, lof_raddr;
  logic [NODE_W-1:0]    lof_wdata, lof_rdata;

  logic [NODE_W-1:0]    nf_m1, nf_p1, lead_m1, rl_c0, rl_c1;
  logic signed [SW-1:0] nf_s, ri_p1, rm_p1;
  logic [LIMIT_W-1:0]   lim_eff;
  logic                 out_load;
  logic                 in_acc;

  assign nf_m1   = nf - 1'b1;
  assign nf_p1   = nf + 1'b1;
  assign lead_m1 = lead - 1'b1;
  assign nf_s    = signed'({1'b0, nf});
  assign ri_p1   = SW'(ri + 1);
  assign rm_p1   = SW'(rm + 1);
  assign rl_c0   = clip(rl_child);
  assign rl_c1   = clip(rl_child + 1'b1);

  assign lim_eff = (rescale_limit < LIMIT_MIN) ? LIMIT_MIN :
                   (rescale_limit > LIMIT_MAX) ? LIMIT_MAX : rescale_limit;

  assign sym_in.ready           = (state == S_IDLE);
  assign in_acc                 = sym_in.valid && sym_in.ready;
  assign out_load               = (state == S_OUT) && (!out_valid || code_out.ready);
  assign code_out.valid         = out_valid;
  assign code_out.code_bits     = out_code;
  assign code_out.code_len      = out_len;
  assign code_out.literal       = out_lit;
  assign code_out.literal_valid = out_lit_valid;

  ahe_ram #(.WIDTH(NODE_REC_W), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  ahe_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_par_ram (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  ahe_ram #(.WIDTH(NODE_W), .DEPTH(LEAF_SLOTS)) u_lof_ram (
    .clk(clk), .we(lof_we), .waddr(lof_waddr), .wdata(lof_wdata),
    .raddr(lof_raddr), .rdata(lof_rdata)
  );

  // memory port control, one access per port per cycle
  always_comb begin
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    par_we     = 1'b0;
    par_waddr  = '0;
    par_wdata  = '0;
    par_raddr  = '0;
    lof_we     = 1'b0;
    lof_waddr  = '0;
    lof_wdata  = '0;
    lof_raddr  = '0;
    case (state)
      S_CLR: begin
        // root with end and escape leaves, everything else zero
        node_we    = (clr_cnt < NODE_COUNT);
        node_waddr = clr_cnt[ADDR_W-1:0];
        if (clr_cnt == CLR_W'(0)) begin
          node_wdata = '{child: NODE_W'(1), leaf: 1'b0, weight: WEIGHT_W'(2)};
        end else if (clr_cnt == CLR_W'(1)) begin
          node_wdata = '{child: SYM_END, leaf: 1'b1, weight: WEIGHT_W'(1)};
        end else if (clr_cnt == CLR_W'(2)) begin
          node_wdata = '{child: SYM_ESC, leaf: 1'b1, weight: WEIGHT_W'(1)};
        end
        par_we    = (clr_cnt < NODE_COUNT);
        par_waddr = clr_cnt[ADDR_W-1:0];
        lof_we    = (clr_cnt < LEAF_SLOTS);
        lof_waddr = clr_cnt[LOF_AW-1:0];
        if (clr_cnt == CLR_W'(SYM_END)) begin
          lof_wdata = NODE_W'(1);
        end else if (clr_cnt == CLR_W'(SYM_ESC)) begin
          lof_wdata = NODE_W'(2);
        end
      end
      S_IDLE: begin
        lof_raddr = sym_in.end_of_stream ? SYM_END[LOF_AW-1:0]
                                         : LOF_AW'(sym_in.symbol);
      end
      S_LOF:  lof_raddr = SYM_ESC[LOF_AW-1:0];
      S_ENC:  par_raddr = enc_node[ADDR_W-1:0];
      S_ADD0: node_raddr = nf_m1[ADDR_W-1:0];
      S_ADD1: begin
        node_we    = 1'b1;
        node_waddr = nf[ADDR_W-1:0];
        node_wdata = node_rdata;
      end
      S_ADD2: begin
        par_we    = 1'b1;
        par_waddr = nf[ADDR_W-1:0];
        par_wdata = nf_m1;
      end
      S_ADD3: begin
        node_we    = 1'b1;
        node_waddr = nf_m1[ADDR_W-1:0];
        node_wdata = '{child: nf, leaf: 1'b0, weight: rec_a.weight};
        par_we     = 1'b1;
        par_waddr  = nf_p1[ADDR_W-1:0];
        par_wdata  = nf_m1;
        lof_we     = 1'b1;
        lof_waddr  = LOF_AW'(sym_q);
        lof_wdata  = nf_p1;
      end
      S_ADD4: begin
        node_we    = 1'b1;
        node_waddr = nf_p1[ADDR_W-1:0];
        node_wdata = '{child: NODE_W'(sym_q), leaf: 1'b1, weight: '0};
      end
      S_UPD0: node_raddr = '0;
      S_UPD2: lof_raddr = LOF_AW'(sym_q);
      S_WALK: node_raddr = cur[ADDR_W-1:0];
      S_SCAN: node_raddr = lead_m1[ADDR_W-1:0];
      S_SWP: begin
        if (lead == cur) begin
          node_we    = 1'b1;
          node_waddr = cur[ADDR_W-1:0];
          node_wdata = rec_a;
        end else begin
          node_raddr = lead[ADDR_W-1:0];
        end
      end
      S_SWP3: begin
        node_we    = 1'b1;
        node_waddr = cur[ADDR_W-1:0];
        node_wdata = rec_b;
      end
      S_SWP4: begin
        node_we    = 1'b1;
        node_waddr = lead[ADDR_W-1:0];
        node_wdata = rec_a;
      end
      S_NEXT: par_raddr = cur[ADDR_W-1:0];
      S_P1:   node_raddr = ri[ADDR_W-1:0];
      S_P1W: begin
        node_we    = node_rdata.leaf;
        node_waddr = rj[ADDR_W-1:0];
        node_wdata = '{child: node_rdata.child, leaf: 1'b1,
                       weight: WEIGHT_W'(({1'b0, node_rdata.weight} + 1'b1) >> 1)};
      end
      S_P2:   node_raddr = ri[ADDR_W-1:0];
      S_P2A:  node_raddr = ri_p1[ADDR_W-1:0];
      S_P2K:  node_raddr = rk[ADDR_W-1:0];
      S_P2M:  node_raddr = rm_p1[ADDR_W-1:0];
      S_P2MW: begin
        node_we    = 1'b1;
        node_waddr = rm[ADDR_W-1:0];
        node_wdata = node_rdata;
      end
      S_P2F: begin
        node_we    = 1'b1;
        node_waddr = rk[ADDR_W-1:0];
        node_wdata = '{child: ri[NODE_W-1:0], leaf: 1'b0, weight: wsum};
      end
      S_P3:   node_raddr = ri[ADDR_W-1:0];
      S_RL0: begin
        if (rl_leaf) begin
          lof_we    = (rl_child < LEAF_SLOTS);
          lof_waddr = rl_child[LOF_AW-1:0];
          lof_wdata = rl_pos;
        end else begin
          par_we    = 1'b1;
          par_waddr = rl_c0[ADDR_W-1:0];
          par_wdata = rl_pos;
        end
      end
      S_RL1: begin
        par_we    = 1'b1;
        par_waddr = rl_c1[ADDR_W-1:0];
        par_wdata = rl_pos;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_cnt       <= '0;
      nf            <= NODE_W'(3);
      rescale_limit <= LIMIT_MAX;
      out_valid     <= 1'b0;
      rl_ret        <= S_IDLE;
    end else begin
      if (cfg_wr_en) begin
        rescale_limit <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (code_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
            nf    <= NODE_W'(3);
            state <= S_IDLE;
          end
        end
        S_IDLE:  if (in_acc) state <= S_LOF;
        S_LOF: begin
          if (eos_q || lof_rdata != '0) begin
            state <= S_ENC;
          end else begin
            state <= S_ESC;
          end
        end
        S_ESC:   state <= S_ENC;
        S_ENC: begin
          if (enc_node == '0 || steps == NODE_W'(NODE_COUNT)) begin
            state <= S_OUT;
          end else begin
            state <= S_ENC_W;
          end
        end
        S_ENC_W: state <= S_ENC;
        S_OUT: begin
          if (out_load) begin
            if (eos_q) begin
              clr_cnt <= '0;
              state   <= S_CLR;
            end else if (lit_q && ({1'b0, nf} + 1'b1 + 1'b1) <= NODE_COUNT) begin
              state <= S_ADD0;
            end else begin
              state <= S_UPD0;
            end
          end
        end
        S_ADD0:  state <= S_ADD1;
        S_ADD1:  state <= S_ADD2;
        S_ADD2: begin
          rl_ret <= S_ADD3;
          state  <= S_RL0;
        end
        S_ADD3:  state <= S_ADD4;
        S_ADD4: begin
          nf    <= nf + NODE_W'(2);
          state <= S_UPD0;
        end
        S_UPD0:  state <= S_UPD1;
        S_UPD1:  state <= (node_rdata.weight >= lim_eff) ? S_P1 : S_UPD2;
        S_UPD2:  state <= S_UPD3;
        S_UPD3:  state <= (clip(lof_rdata) == '0) ? S_IDLE : S_WALK;
        S_WALK:  state <= (steps == NODE_W'(NODE_COUNT)) ? S_IDLE : S_WALK1;
        S_WALK1: state <= S_SCAN;
        S_SCAN:  state <= (lead > NODE_W'(1)) ? S_SCAN1 : S_SWP;
        S_SCAN1: state <= (node_rdata.weight < rec_a.weight) ? S_SCAN : S_SWP;
        S_SWP:   state <= (lead == cur) ? S_NEXT : S_SWP1;
        S_SWP1: begin
          rl_ret <= S_SWP2;
          state  <= S_RL0;
        end
        S_SWP2: begin
          rl_ret <= S_SWP3;
          state  <= S_RL0;
        end
        S_SWP3:  state <= S_SWP4;
        S_SWP4:  state <= S_NEXT;
        S_NEXT:  state <= (cur == '0) ? S_IDLE : S_NEXT1;
        S_NEXT1: state <= S_WALK;
        S_P1:    state <= ri[SW-1] ? S_P2 : S_P1W;
        S_P1W:   state <= S_P1;
        S_P2: begin
          if (!rj[SW-1] && !ri[SW-1] && ri_p1 < nf_s) begin
            state <= S_P2A;
          end else begin
            state <= S_P3;
          end
        end
        S_P2A:   state <= S_P2B;
        S_P2B:   state <= S_P2K;
        S_P2K:   state <= (rk < nf_s) ? S_P2KW : S_P2M;
        S_P2KW:  state <= (wsum < node_rdata.weight) ? S_P2K : S_P2M;
        S_P2M:   state <= (rm < rk) ? S_P2MW : S_P2F;
        S_P2MW:  state <= S_P2M;
        S_P2F:   state <= S_P2;
        S_P3:    state <= ri[SW-1] ? S_UPD2 : S_P3W;
        S_P3W: begin
          rl_ret <= S_P3;
          state  <= S_RL0;
        end
        S_RL0:   state <= rl_leaf ? rl_ret : S_RL1;
        S_RL1:   state <= rl_ret;
        default: state <= S_CLR;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code      <= code;
      out_len       <= len;
      out_lit       <= lit_q ? sym_q : '0;
      out_lit_valid <= lit_q;
    end
    case (state)
      S_IDLE: begin
        sym_q <= sym_in.symbol;
        eos_q <= sym_in.end_of_stream;
        lit_q <= 1'b0;
      end
      S_LOF, S_ESC: begin
        enc_node <= clip(lof_rdata);
        code     <= '0;
        len      <= '0;
        steps    <= '0;
        if (state == S_ESC) begin
          lit_q <= 1'b1;
        end
      end
      S_ENC: begin
        if (enc_node != '0 && steps != NODE_W'(NODE_COUNT)) begin
          // leaf-side bits land low; even index means right child, bit 1
          if (len < MAX_CODE_BITS) begin
            code[len[4:0]] <= ~enc_node[0];
            len            <= len + 1'b1;
          end
          steps <= steps + 1'b1;
        end
      end
      S_ENC_W: enc_node <= clip(par_rdata);
      S_ADD1: begin
        rec_a    <= node_rdata;
        rl_child <= node_rdata.child;
        rl_leaf  <= node_rdata.leaf;
        rl_pos   <= nf;
      end
      S_UPD1: begin
        ri <= SW'(nf_s - 1);
        rj <= SW'(nf_s - 1);
      end
      S_UPD3: begin
        cur   <= clip(lof_rdata);
        steps <= '0;
      end
      S_WALK1: begin
        rec_a        <= node_rdata;
        rec_a.weight <= node_rdata.weight + 1'b1;
        lead         <= cur;
      end
      S_SCAN1: if (node_rdata.weight < rec_a.weight) lead <= lead_m1;
      S_SWP1: begin
        rec_b    <= node_rdata;
        rl_child <= rec_a.child;
        rl_leaf  <= rec_a.leaf;
        rl_pos   <= lead;
      end
      S_SWP2: begin
        rl_child <= rec_b.child;
        rl_leaf  <= rec_b.leaf;
        rl_pos   <= cur;
      end
      S_SWP4:  cur <= lead;
      S_NEXT1: begin
        cur   <= clip(par_rdata);
        steps <= steps + 1'b1;
      end
      // rebuild, phase one: pack halved leaves at the top
      S_P1: if (ri[SW-1]) ri <= SW'(nf_s - 2);
      S_P1W: begin
        ri <= SW'(ri - 1);
        if (node_rdata.leaf) rj <= SW'(rj - 1);
      end
      // phase two: pair up from the bottom, insert the parent in weight order
      S_P2: if (!(!rj[SW-1] && !ri[SW-1] && ri_p1 < nf_s)) ri <= SW'(nf_s - 1);
      S_P2A: wsum <= node_rdata.weight;
      S_P2B: begin
        wsum <= wsum + node_rdata.weight;
        rk   <= SW'(rj + 1);
      end
      S_P2K: begin
        if (!(rk < nf_s)) begin
          rk <= SW'(rk - 1);
          rm <= rj;
        end
      end
      S_P2KW: begin
        if (wsum < node_rdata.weight) begin
          rk <= SW'(rk + 1);
        end else begin
          rk <= SW'(rk - 1);
          rm <= rj;
        end
      end
      S_P2MW: rm <= rm_p1;
      S_P2F: begin
        ri <= SW'(ri - 2);
        rj <= SW'(rj - 1);
      end
      // phase three: relink every node in place
      S_P3W: begin
        rl_child <= node_rdata.child;
        rl_leaf  <= node_rdata.leaf;
        rl_pos   <= ri[NODE_W-1:0];
        ri       <= SW'(ri - 1);
      end
      default: ;
    endcase
  end

  // a taken item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !sym_in.ready)
    else $error("input taken twice in a row");

  // free pointer stays odd and no greater than NODE_COUNT whenever idle
  a_next_free_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (nf[0] && nf <= NODE_COUNT))
    else $error("next free node out of range");

  // every result carries at least one code bit and no more than the cap
  a_code_len_ok: assert property (@(posedge clk) disable iff (rst)
    code_out.valid |-> (code_out.code_len != '0 && code_out.code_len <= MAX_CODE_BITS))
    else $error("bad code length");

  // a result is loaded only from the output state
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result loaded outside output state");

endmodule
